/* sv/aicl_pkg.sv */
// ----------------------------------------------------------------------------
// aicl_pkg
// Shared codes, widths and helper functions for the access ID class lookup.
// ----------------------------------------------------------------------------
package aicl_pkg;

  localparam int unsigned ID_W  = 24;
  localparam int unsigned EN_W  = 8;
  localparam int unsigned SEL_W = 4;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned CLS_W = 4;

  localparam logic [ID_W-1:0] ERASED_ID = {ID_W{1'b1}};

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // list codes, also the order in which the search walks the lists
  localparam logic [SEL_W-1:0] LS_FIRST    = 4'd0;
  localparam logic [SEL_W-1:0] LS_GROUP    = 4'd1;
  localparam logic [SEL_W-1:0] LS_SUPER    = 4'd2;
  localparam logic [SEL_W-1:0] LS_SUPERPW  = 4'd3;
  localparam logic [SEL_W-1:0] LS_THREAT   = 4'd4;
  localparam logic [SEL_W-1:0] LS_THREATPW = 4'd5;
  localparam logic [SEL_W-1:0] LS_KEYPAD   = 4'd6;
  localparam logic [SEL_W-1:0] LS_FINGER   = 4'd7;
  localparam logic [SEL_W-1:0] LS_GENERAL  = 4'd8;

  localparam logic [CLS_W-1:0] CLS_FIRST    = 4'd0;
  localparam logic [CLS_W-1:0] CLS_GROUP    = 4'd1;
  localparam logic [CLS_W-1:0] CLS_SUPER    = 4'd2;
  localparam logic [CLS_W-1:0] CLS_SUPERPW  = 4'd3;
  localparam logic [CLS_W-1:0] CLS_THREAT   = 4'd4;
  localparam logic [CLS_W-1:0] CLS_THREATPW = 4'd5;
  localparam logic [CLS_W-1:0] CLS_KEYPAD   = 4'd6;
  localparam logic [CLS_W-1:0] CLS_GENERAL  = 4'd7;
  localparam logic [CLS_W-1:0] CLS_NONE     = 4'd8;

  // enable bit positions
  localparam int unsigned EN_FIRST    = 1;
  localparam int unsigned EN_GROUP    = 2;
  localparam int unsigned EN_SUPER    = 3;
  localparam int unsigned EN_SUPERPW  = 4;
  localparam int unsigned EN_THREAT   = 5;
  localparam int unsigned EN_THREATPW = 6;
  localparam int unsigned EN_KEYPAD   = 7;

  function automatic logic list_enabled(logic [SEL_W-1:0] region, logic [EN_W-1:0] en);
    logic r;
    r = 1'b0;
    case (region)
      LS_FIRST:    r = en[EN_FIRST];
      LS_GROUP:    r = en[EN_GROUP];
      LS_SUPER:    r = en[EN_SUPER];
      LS_SUPERPW:  r = en[EN_SUPERPW];
      LS_THREAT:   r = en[EN_THREAT];
      LS_THREATPW: r = en[EN_THREATPW];
      LS_KEYPAD:   r = en[EN_KEYPAD];
      LS_FINGER:   r = en[EN_KEYPAD];
      LS_GENERAL:  r = 1'b1;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [CLS_W-1:0] class_of(logic [SEL_W-1:0] region);
    logic [CLS_W-1:0] c;
    c = CLS_NONE;
    case (region)
      LS_FIRST:    c = CLS_FIRST;
      LS_GROUP:    c = CLS_GROUP;
      LS_SUPER:    c = CLS_SUPER;
      LS_SUPERPW:  c = CLS_SUPERPW;
      LS_THREAT:   c = CLS_THREAT;
      LS_THREATPW: c = CLS_THREATPW;
      LS_KEYPAD:   c = CLS_KEYPAD;
      LS_FINGER:   c = CLS_THREAT;
      LS_GENERAL:  c = CLS_GENERAL;
      default:     c = CLS_NONE;
    endcase
    return c;
  endfunction

endpackage

/* sv/aicl_id_mem.sv */
// ----------------------------------------------------------------------------
// aicl_id_mem
// Single-port-write, single-port-read ID store with registered read data.
// ----------------------------------------------------------------------------
module aicl_id_mem #(
  parameter int unsigned DEPTH = 1049,
  parameter int unsigned AW    = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [aicl_pkg::ID_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [aicl_pkg::ID_W-1:0] rdata_o
);
  import aicl_pkg::*;

  logic [ID_W-1:0] mem_q [DEPTH];
  logic [ID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/aicl_seq.sv */
// ----------------------------------------------------------------------------
// aicl_seq
// Sequencer: clearing pass, entry writes and the linear search over all lists
// through one shared 24-bit compare.
// ----------------------------------------------------------------------------
module aicl_seq #(
  parameter int unsigned GENERAL_DEPTH = 512,
  parameter int unsigned FINGER_DEPTH  = 512,
  parameter int unsigned GROUP_DEPTH   = 16,
  parameter int unsigned THREAT_DEPTH  = 4,
  localparam int unsigned TOTAL = GENERAL_DEPTH + FINGER_DEPTH + GROUP_DEPTH
                                  + THREAT_DEPTH + 5,
  localparam int unsigned AW = $clog2(TOTAL)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       opcode_i,
  input  logic [aicl_pkg::SEL_W-1:0] list_select_i,
  input  logic [aicl_pkg::IDX_W-1:0] entry_index_i,
  input  logic [aicl_pkg::ID_W-1:0]  card_id_i,
  input  logic [aicl_pkg::EN_W-1:0]  enables_i,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [aicl_pkg::ID_W-1:0]  mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [aicl_pkg::ID_W-1:0]  mem_rdata_i,
  output logic                       result_valid_o,
  output logic [aicl_pkg::CLS_W-1:0] match_class_o
);
  import aicl_pkg::*;

  localparam int unsigned CW = $clog2(TOTAL + 1);

  localparam int unsigned B_FIRST    = 0;
  localparam int unsigned B_GROUP    = B_FIRST + 1;
  localparam int unsigned B_SUPER    = B_GROUP + GROUP_DEPTH;
  localparam int unsigned B_SUPERPW  = B_SUPER + 1;
  localparam int unsigned B_THREAT   = B_SUPERPW + 1;
  localparam int unsigned B_THREATPW = B_THREAT + THREAT_DEPTH;
  localparam int unsigned B_KEYPAD   = B_THREATPW + 1;
  localparam int unsigned B_FINGER   = B_KEYPAD + 1;
  localparam int unsigned B_GENERAL  = B_FINGER + FINGER_DEPTH;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0]       state_q;
  logic [CW-1:0]    addr_q;
  logic             pend_q;
  logic             last_q;
  logic             done_q;
  logic [ID_W-1:0]  key_q;
  logic [SEL_W-1:0] preg_q;
  logic [CLS_W-1:0] class_q;

  logic [SEL_W-1:0] region;
  logic             accept;
  logic             issue;
  logic             hit;
  logic             finish;
  logic             wr_ok;
  int unsigned      wr_loc;
  int unsigned      idx;

  // list that the current read address falls in
  always_comb begin
    if (addr_q >= CW'(B_GENERAL)) begin
      region = LS_GENERAL;
    end else if (addr_q >= CW'(B_FINGER)) begin
      region = LS_FINGER;
    end else if (addr_q >= CW'(B_KEYPAD)) begin
      region = LS_KEYPAD;
    end else if (addr_q >= CW'(B_THREATPW)) begin
      region = LS_THREATPW;
    end else if (addr_q >= CW'(B_THREAT)) begin
      region = LS_THREAT;
    end else if (addr_q >= CW'(B_SUPERPW)) begin
      region = LS_SUPERPW;
    end else if (addr_q >= CW'(B_SUPER)) begin
      region = LS_SUPER;
    end else if (addr_q >= CW'(B_GROUP)) begin
      region = LS_GROUP;
    end else begin
      region = LS_FIRST;
    end
  end

  // entry write address decode
  always_comb begin
    idx    = int'(entry_index_i);
    wr_ok  = 1'b0;
    wr_loc = 0;
    case (list_select_i)
      LS_FIRST: begin
        wr_ok  = 1'b1;
        wr_loc = B_FIRST;
      end
      LS_GROUP: begin
        wr_ok  = idx < GROUP_DEPTH;
        wr_loc = B_GROUP + idx;
      end
      LS_SUPER: begin
        wr_ok  = 1'b1;
        wr_loc = B_SUPER;
      end
      LS_SUPERPW: begin
        wr_ok  = 1'b1;
        wr_loc = B_SUPERPW;
      end
      LS_THREAT: begin
        wr_ok  = idx < THREAT_DEPTH;
        wr_loc = B_THREAT + idx;
      end
      LS_THREATPW: begin
        wr_ok  = 1'b1;
        wr_loc = B_THREATPW;
      end
      LS_KEYPAD: begin
        wr_ok  = 1'b1;
        wr_loc = B_KEYPAD;
      end
      LS_FINGER: begin
        wr_ok  = idx < FINGER_DEPTH;
        wr_loc = B_FINGER + idx;
      end
      LS_GENERAL: begin
        wr_ok  = idx < GENERAL_DEPTH;
        wr_loc = B_GENERAL + idx;
      end
      default: begin
        wr_ok  = 1'b0;
        wr_loc = 0;
      end
    endcase
  end

  assign accept = start_i && (state_q == ST_IDLE);
  assign issue  = (state_q == ST_SCAN) && (addr_q < CW'(TOTAL));
  assign hit    = pend_q && list_enabled(preg_q, enables_i) && (mem_rdata_i == key_q);
  assign finish = hit || (pend_q && last_q);

  assign mem_we_o    = (state_q == ST_CLEAR) || (accept && (opcode_i == OP_WRITE) && wr_ok);
  assign mem_waddr_o = (state_q == ST_CLEAR) ? addr_q[AW-1:0] : AW'(wr_loc);
  assign mem_wdata_o = (state_q == ST_CLEAR) ? ERASED_ID : card_id_i;
  assign mem_re_o    = issue;
  assign mem_raddr_o = addr_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          if (addr_q == CW'(TOTAL - 1)) begin
            state_q <= ST_IDLE;
            addr_q  <= '0;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          pend_q <= 1'b0;
          last_q <= 1'b0;
          if (accept && (opcode_i == OP_SEARCH)) begin
            state_q <= ST_SCAN;
            addr_q  <= '0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            addr_q <= addr_q + 1'b1;
          end
          pend_q <= issue;
          last_q <= issue && (addr_q == CW'(TOTAL - 1));
          if (finish) begin
            state_q <= ST_IDLE;
            pend_q  <= 1'b0;
            last_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= card_id_i;
    end
    preg_q <= region;
    if (finish) begin
      class_q <= hit ? class_of(preg_q) : CLS_NONE;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = done_q;
  assign match_class_o  = class_q;

endmodule

/* sv/access_id_class_lookup.sv */
// ----------------------------------------------------------------------------
// access_id_class_lookup
// Classifies a 24-bit card or code ID against stored ID lists.
//
//   channel   direction  handshake                  payload
//   command   in         start & !busy              opcode, list_select,
//                                                   entry_index, card_id
//   result    out        result_valid_o strobe      match_class_o
//   config    in         cfg_valid_i & cfg_ready_o  cfg_data_i (category enables)
//
// All lists live in one memory, laid out in search order; a search reads one
// entry per cycle through a single compare and ends early on a match.
// An entry write gives no result.
// After reset a clearing pass erases the memory; busy is high meanwhile.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module access_id_class_lookup #(
  parameter int unsigned GENERAL_DEPTH = 512,
  parameter int unsigned FINGER_DEPTH  = 512,
  parameter int unsigned GROUP_DEPTH   = 16,
  parameter int unsigned THREAT_DEPTH  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode_i,
  input  logic [aicl_pkg::SEL_W-1:0] list_select_i,
  input  logic [aicl_pkg::IDX_W-1:0] entry_index_i,
  input  logic [aicl_pkg::ID_W-1:0]  card_id_i,
  output logic                       result_valid_o,
  output logic [aicl_pkg::CLS_W-1:0] match_class_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [aicl_pkg::EN_W-1:0]  cfg_data_i
);
  import aicl_pkg::*;

  localparam int unsigned TOTAL = GENERAL_DEPTH + FINGER_DEPTH + GROUP_DEPTH
                                  + THREAT_DEPTH + 5;
  localparam int unsigned AW = $clog2(TOTAL);

  logic [EN_W-1:0] enables_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ID_W-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [ID_W-1:0] mem_rdata;

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enables_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enables_q <= cfg_data_i;
    end
  end

  aicl_seq #(
    .GENERAL_DEPTH (GENERAL_DEPTH),
    .FINGER_DEPTH  (FINGER_DEPTH),
    .GROUP_DEPTH   (GROUP_DEPTH),
    .THREAT_DEPTH  (THREAT_DEPTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .opcode_i       (opcode_i),
    .list_select_i  (list_select_i),
    .entry_index_i  (entry_index_i),
    .card_id_i      (card_id_i),
    .enables_i      (enables_q),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .match_class_o  (match_class_o)
  );

  aicl_id_mem #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

/* sv/aicl_checker.sv */
// ----------------------------------------------------------------------------
// aicl_checker
// Port-level checks on the access ID class lookup, bound to the top level.
// ----------------------------------------------------------------------------
module aicl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       opcode_i,
  input logic                       result_valid_o,
  input logic [aicl_pkg::CLS_W-1:0] match_class_o
);
  import aicl_pkg::*;

  // a search gives one strobe, never two in a row
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (match_class_o <= CLS_NONE))
    else $error("match class out of range");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_SEARCH)) |=> busy)
    else $error("search transfer did not raise busy");

  a_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_WRITE)) |=> (!busy && !result_valid_o))
    else $error("entry write caused busy or a result");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

endmodule

bind access_id_class_lookup aicl_checker u_aicl_checker (.*);

/* tb/sv/access_id_class_lookup_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// access_id_class_lookup_checker
// Watches the command, result and enable-write channels of the ID class
// lookup. It keeps its own copy of every ID list and of the category
// enables, works out the class of each accepted search, and compares every
// result strobe against the oldest class still waiting.
// ----------------------------------------------------------------------------
module access_id_class_lookup_checker #(
  parameter int unsigned GENERAL_DEPTH = 512,
  parameter int unsigned FINGER_DEPTH  = 512,
  parameter int unsigned GROUP_DEPTH   = 16,
  parameter int unsigned THREAT_DEPTH  = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       opcode_i,
  input  logic [aicl_pkg::SEL_W-1:0] list_select_i,
  input  logic [aicl_pkg::IDX_W-1:0] entry_index_i,
  input  logic [aicl_pkg::ID_W-1:0]  card_id_i,
  input  logic                       result_valid_i,
  input  logic [aicl_pkg::CLS_W-1:0] match_class_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [aicl_pkg::EN_W-1:0]  cfg_data_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  import aicl_pkg::*;

  logic [ID_W-1:0]  general_ids [GENERAL_DEPTH];
  logic [ID_W-1:0]  finger_ids  [FINGER_DEPTH];
  logic [ID_W-1:0]  group_ids   [GROUP_DEPTH];
  logic [ID_W-1:0]  threat_ids  [THREAT_DEPTH];
  logic [ID_W-1:0]  first_id;
  logic [ID_W-1:0]  super_id;
  logic [ID_W-1:0]  super_code;
  logic [ID_W-1:0]  threat_code;
  logic [ID_W-1:0]  keypad_id;
  logic [EN_W-1:0]  enables;
  logic [CLS_W-1:0] expected_classes [$];
  logic [CLS_W-1:0] expected_class;

  function automatic logic [CLS_W-1:0] predict_class(logic [ID_W-1:0] key);
    if (enables[EN_FIRST] && first_id == key) return CLS_FIRST;
    if (enables[EN_GROUP]) begin
      foreach (group_ids[k]) if (group_ids[k] == key) return CLS_GROUP;
    end
    if (enables[EN_SUPER] && super_id == key) return CLS_SUPER;
    if (enables[EN_SUPERPW] && super_code == key) return CLS_SUPERPW;
    if (enables[EN_THREAT]) begin
      foreach (threat_ids[k]) if (threat_ids[k] == key) return CLS_THREAT;
    end
    if (enables[EN_THREATPW] && threat_code == key) return CLS_THREATPW;
    if (enables[EN_KEYPAD]) begin
      if (keypad_id == key) return CLS_KEYPAD;
      // fingerprint hits report the threat class
      foreach (finger_ids[k]) if (finger_ids[k] == key) return CLS_THREAT;
    end
    foreach (general_ids[k]) if (general_ids[k] == key) return CLS_GENERAL;
    return CLS_NONE;
  endfunction

  function automatic void store_entry(logic [SEL_W-1:0] sel, logic [IDX_W-1:0] idx,
                                      logic [ID_W-1:0] id);
    case (sel)
      LS_FIRST:    first_id = id;
      LS_GROUP:    if (idx < GROUP_DEPTH) group_ids[idx] = id;
      LS_SUPER:    super_id = id;
      LS_SUPERPW:  super_code = id;
      LS_THREAT:   if (idx < THREAT_DEPTH) threat_ids[idx] = id;
      LS_THREATPW: threat_code = id;
      LS_KEYPAD:   keypad_id = id;
      LS_FINGER:   if (idx < FINGER_DEPTH) finger_ids[idx] = id;
      LS_GENERAL:  if (idx < GENERAL_DEPTH) general_ids[idx] = id;
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (general_ids[k]) general_ids[k] = ERASED_ID;
      foreach (finger_ids[k]) finger_ids[k] = ERASED_ID;
      foreach (group_ids[k]) group_ids[k] = ERASED_ID;
      foreach (threat_ids[k]) threat_ids[k] = ERASED_ID;
      first_id     = ERASED_ID;
      super_id     = ERASED_ID;
      super_code   = ERASED_ID;
      threat_code  = ERASED_ID;
      keypad_id    = ERASED_ID;
      enables      = '0;
      expected_classes.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_classes.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual match_class %0d",
                   $time, match_class_i);
          fail_count_o++;
        end else begin
          expected_class = expected_classes.pop_front();
          if (match_class_i !== expected_class) begin
            $display("%0t ns: match_class mismatch, expected %0d, actual %0d",
                     $time, expected_class, match_class_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) enables = cfg_data_i;
      if (start_i && !busy_i) begin
        if (opcode_i == OP_SEARCH) begin
          expected_classes.push_back(predict_class(card_id_i));
        end else begin
          store_entry(list_select_i, entry_index_i, card_id_i);
        end
      end
      pending_o = expected_classes.size();
    end
  end

endmodule

/* tb/sv/access_id_class_lookup_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// access_id_class_lookup_test
// Drives list writes and ID searches into the lookup under a series of
// category enable settings, first a directed set covering each list, the
// priority order and the corner cases, then random traffic built around a
// small pool of IDs so that searches hit often. A checker beside the block
// predicts and compares every class; this module gives the verdict.
// ----------------------------------------------------------------------------
module access_id_class_lookup_test;

  import aicl_pkg::*;

  localparam int unsigned GENERAL_DEPTH = 512;
  localparam int unsigned FINGER_DEPTH  = 512;
  localparam int unsigned GROUP_DEPTH   = 16;
  localparam int unsigned THREAT_DEPTH  = 4;
  localparam int unsigned PHASE_ITEMS   = 64;
  localparam int unsigned DRAIN_CYCLES  = 1100;
  localparam int unsigned RUN_LIMIT_NS  = 40_000_000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             opcode_i;
  logic [SEL_W-1:0] list_select_i;
  logic [IDX_W-1:0] entry_index_i;
  logic [ID_W-1:0]  card_id_i;
  logic             result_valid_o;
  logic [CLS_W-1:0] match_class_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [EN_W-1:0]  cfg_data_i;
  int unsigned      fail_count;
  int unsigned      pending;

  int unsigned      n_writes;
  int unsigned      n_searches;
  int unsigned      n_settings;
  bit               no_idle;
  logic [ID_W-1:0]  id_pool [16];
  logic [EN_W-1:0]  phase_enables [8] = '{8'h00, 8'hFF, 8'h01, 8'hFE,
                                         8'h80, 8'h7F, 8'hAA, 8'h55};

  access_id_class_lookup #(
    .GENERAL_DEPTH(GENERAL_DEPTH),
    .FINGER_DEPTH (FINGER_DEPTH),
    .GROUP_DEPTH  (GROUP_DEPTH),
    .THREAT_DEPTH (THREAT_DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .list_select_i (list_select_i),
    .entry_index_i (entry_index_i),
    .card_id_i     (card_id_i),
    .result_valid_o(result_valid_o),
    .match_class_o (match_class_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  access_id_class_lookup_checker #(
    .GENERAL_DEPTH(GENERAL_DEPTH),
    .FINGER_DEPTH (FINGER_DEPTH),
    .GROUP_DEPTH  (GROUP_DEPTH),
    .THREAT_DEPTH (THREAT_DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .opcode_i      (opcode_i),
    .list_select_i (list_select_i),
    .entry_index_i (entry_index_i),
    .card_id_i     (card_id_i),
    .result_valid_i(result_valid_o),
    .match_class_i (match_class_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(8, 1200);
  endfunction

  // called at a rising edge; returns at the edge of the transfer or after the gap
  task automatic send_command(input logic op, input logic [SEL_W-1:0] sel,
                              input logic [IDX_W-1:0] idx, input logic [ID_W-1:0] id);
    int unsigned gap;
    gap = pick_gap();
    opcode_i      <= op;
    list_select_i <= sel;
    entry_index_i <= idx;
    card_id_i     <= id;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (op == OP_SEARCH) n_searches++;
    else n_writes++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_enables(input logic [EN_W-1:0] value);
    wait_idle();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic run_random(input int unsigned count);
    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  id;
    int unsigned      depth;
    int unsigned      r;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 55) begin
        sel = SEL_W'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                  : $urandom_range(0, 8));
        case (sel)
          LS_GROUP:   depth = GROUP_DEPTH;
          LS_THREAT:  depth = THREAT_DEPTH;
          LS_FINGER:  depth = FINGER_DEPTH;
          LS_GENERAL: depth = GENERAL_DEPTH;
          default:    depth = 512;
        endcase
        idx = IDX_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 511)
                                                 : $urandom_range(0, depth - 1));
        if (r < 8) begin
          id = ERASED_ID;
        end else if (r < 75) begin
          id = id_pool[$urandom_range(0, 15)];
        end else begin
          id = ID_W'($urandom);
          id_pool[$urandom_range(0, 15)] = id;
        end
        send_command(OP_WRITE, sel, idx, id);
      end else begin
        if (r < 12) id = ERASED_ID;
        else if (r < 72) id = id_pool[$urandom_range(0, 15)];
        else id = ID_W'($urandom);
        send_command(OP_SEARCH, SEL_W'($urandom), IDX_W'($urandom), id);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    opcode_i      = OP_WRITE;
    list_select_i = '0;
    entry_index_i = '0;
    card_id_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    n_writes      = 0;
    n_searches    = 0;
    n_settings    = 0;
    no_idle       = 1'b0;
    foreach (id_pool[k]) id_pool[k] = ID_W'($urandom);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // enables at reset value: only the general list takes part
    send_command(OP_SEARCH, LS_FIRST, '0, ERASED_ID);
    send_command(OP_SEARCH, LS_GENERAL, '1, 24'h000000);

    write_enables(8'hFF);
    send_command(OP_WRITE, LS_FIRST, 9'd511, 24'h000000);
    send_command(OP_WRITE, LS_GROUP, 9'd15, 24'h123456);
    send_command(OP_WRITE, LS_GROUP, 9'd16, 24'h654321);
    send_command(OP_WRITE, LS_SUPER, 9'd0, 24'hABCDEF);
    send_command(OP_WRITE, LS_SUPERPW, 9'd200, 24'h111111);
    send_command(OP_WRITE, LS_THREAT, 9'd3, 24'h222222);
    send_command(OP_WRITE, LS_THREATPW, 9'd1, 24'h333333);
    send_command(OP_WRITE, LS_KEYPAD, 9'd7, 24'h444444);
    send_command(OP_WRITE, LS_FINGER, 9'd511, 24'h555555);
    send_command(OP_WRITE, LS_GENERAL, 9'd511, 24'h800000);
    send_command(OP_WRITE, 4'd15, 9'd0, 24'h777777);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h000000);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h123456);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h654321);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'hABCDEF);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h111111);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h222222);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h333333);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h444444);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h555555);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h800000);
    send_command(OP_SEARCH, LS_FIRST, '0, 24'h777777);
    send_command(OP_SEARCH, LS_FIRST, '0, ERASED_ID);

    foreach (phase_enables[p]) begin
      write_enables(phase_enables[p]);
      no_idle = (p % 3 == 2);
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d list writes and %0d searches over %0d enable settings",
             n_writes, n_searches, n_settings);
    $display("%0d class mismatches or stray results", fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("timeout with %0d searches still pending", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
